[hdl/cigr_pkg.sv]
package cigr_pkg;

  localparam int CHAR_BITS  = 8;
  localparam int START_BITS = 31;
  localparam int FLAG_BITS  = 16;
  localparam int SPAN_BITS  = 32;

  // flag word bit that marks the reverse strand
  localparam int REV_FLAG_BIT = 4;

  localparam logic [CHAR_BITS-1:0] CH_0 = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9 = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_S = 8'h53;
  localparam logic [CHAR_BITS-1:0] CH_M = 8'h4D;
  localparam logic [CHAR_BITS-1:0] CH_N = 8'h4E;
  localparam logic [CHAR_BITS-1:0] CH_I = 8'h49;
  localparam logic [CHAR_BITS-1:0] CH_D = 8'h44;
  localparam logic [CHAR_BITS-1:0] CH_X = 8'h58;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_X     = 2'd1,
    ERR_NO_OP = 2'd2,
    ERR_STRAY = 2'd3
  } err_t;

endpackage

[hdl/cigr_in_if.sv]
interface cigr_in_if import cigr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CHAR_BITS-1:0]  cigar_char;
  logic [START_BITS-1:0] start_pos;
  logic [FLAG_BITS-1:0]  sam_flags;
  logic                  last_char;

  modport source (output valid, cigar_char, start_pos, sam_flags, last_char, input ready);
  modport sink (input valid, cigar_char, start_pos, sam_flags, last_char, output ready);
endinterface

[hdl/cigr_out_if.sv]
interface cigr_out_if import cigr_pkg::*; #(
  parameter int LEN_BITS = 28,
  parameter int POS_BITS = 31
) ();
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] end_pos;
  logic [LEN_BITS-1:0] head_clip;
  logic [LEN_BITS-1:0] tail_clip;
  logic                is_forward;
  err_t                error_code;

  modport source (output valid, end_pos, head_clip, tail_clip, is_forward, error_code,
                  input ready);
  modport sink (input valid, end_pos, head_clip, tail_clip, is_forward, error_code,
                output ready);
endinterface

[hdl/cigar_reference_span_parser.sv]
// CIGAR parser: takes one CIGAR character per word, with the start position and
// SAM flags alongside, and gives one result word for the word marked last_char
// (end position, head and tail soft clips, strand, error code). It takes a word
// every cycle while in_ch.ready is high; the state update for a character is
// one register stage, and a result reaches the output through two register
// stages (one for the final character, one for the end-position add and
// clamp).
// Back-pressure on the output stalls the input only once both result stages
// are full. Once a last character is accepted the parse state is back at reset.
module cigar_reference_span_parser import cigr_pkg::*; #(
  parameter int LEN_BITS = 28,
  parameter int POS_BITS = 31
) (
  input logic         clk,
  input logic         rst_n,
  cigr_in_if.sink     in_ch,
  cigr_out_if.source  out_ch
);

  localparam int ACC_BITS = LEN_BITS + 4;
  localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
  localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
  localparam logic [SPAN_BITS-1:0] SPAN_MAX = '1;

  // parse state
  logic [LEN_BITS-1:0]  len_r, len_nxt;
  logic [SPAN_BITS-1:0] span_r, span_nxt;
  logic [LEN_BITS-1:0]  head_r, head_nxt;
  logic [LEN_BITS-1:0]  tail_r, tail_nxt;
  logic                 op_seen_r, op_seen_nxt;
  err_t                 err_r, err_nxt, err_fin;

  // final-character stage
  logic                  s1_v_r, s1_v_nxt;
  logic [SPAN_BITS-1:0]  s1_span_r;
  logic [START_BITS-1:0] s1_start_r;
  logic [LEN_BITS-1:0]   s1_head_r;
  logic [LEN_BITS-1:0]   s1_tail_r;
  logic                  s1_fwd_r;
  err_t                  s1_err_r;

  // output register
  logic                out_v_r, out_v_nxt;
  logic [POS_BITS-1:0] end_r, end_nxt;
  logic [LEN_BITS-1:0] o_head_r, o_head_nxt;
  logic [LEN_BITS-1:0] o_tail_r, o_tail_nxt;
  logic                o_fwd_r;
  err_t                o_err_r;

  logic                in_fire, is_last, out_take, s1_adv;
  logic                do_close, is_soft, adds_span, is_digit, hit_x, hit_stray;
  logic [ACC_BITS-1:0] len_x10;
  logic [SPAN_BITS:0]  span_sum;
  logic [SPAN_BITS:0]  pos_sum, pos_dec;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign is_last  = in_ch.last_char;
  assign out_take = !out_v_r || out_ch.ready;
  assign s1_adv   = s1_v_r && out_take;
  assign in_ch.ready = !s1_v_r || out_take;

  assign is_digit = (in_ch.cigar_char >= CH_0) && (in_ch.cigar_char <= CH_9);
  // len * 10 + digit, digit value is the low nibble of an ascii digit
  assign len_x10 = (ACC_BITS'(len_r) << 3) + (ACC_BITS'(len_r) << 1)
                 + ACC_BITS'(in_ch.cigar_char[3:0]);
  assign span_sum = {1'b0, span_r} + (SPAN_BITS+1)'(len_r);

  always_comb begin
    do_close  = 1'b0;
    is_soft   = 1'b0;
    adds_span = 1'b0;
    hit_x     = 1'b0;
    hit_stray = 1'b0;
    case (in_ch.cigar_char)
      CH_S: begin
        do_close = 1'b1;
        is_soft  = 1'b1;
      end
      CH_M, CH_D, CH_N: begin
        do_close  = 1'b1;
        adds_span = 1'b1;
      end
      CH_I: begin
        do_close = 1'b1;
      end
      CH_X: begin
        do_close = 1'b1;
        hit_x    = 1'b1;
      end
      default: begin
        hit_stray = !is_digit;
      end
    endcase
  end

  always_comb begin
    len_nxt     = len_r;
    span_nxt    = span_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    op_seen_nxt = op_seen_r;
    err_nxt     = err_r;
    if (is_digit) begin
      len_nxt = (len_x10 > ACC_BITS'(LEN_MAX)) ? LEN_MAX : len_x10[LEN_BITS-1:0];
    end
    if (do_close) begin
      if (adds_span) begin
        span_nxt = span_sum[SPAN_BITS] ? SPAN_MAX : span_sum[SPAN_BITS-1:0];
      end
      if (is_soft) begin
        if (!op_seen_r) begin
          head_nxt = len_r;
        end
        tail_nxt = len_r;
      end else begin
        tail_nxt = '0;
      end
      op_seen_nxt = 1'b1;
      len_nxt     = '0;
    end
    // only the first error of a string is kept
    if (err_r == ERR_NONE) begin
      if (hit_x) begin
        err_nxt = ERR_X;
      end else if (hit_stray) begin
        err_nxt = ERR_STRAY;
      end
    end
    err_fin = err_nxt;
    if (!op_seen_nxt && err_nxt == ERR_NONE) begin
      err_fin = ERR_NO_OP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      span_r    <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      op_seen_r <= 1'b0;
      err_r     <= ERR_NONE;
    end else if (in_fire) begin
      if (is_last) begin
        len_r     <= '0;
        span_r    <= '0;
        head_r    <= '0;
        tail_r    <= '0;
        op_seen_r <= 1'b0;
        err_r     <= ERR_NONE;
      end else begin
        len_r     <= len_nxt;
        span_r    <= span_nxt;
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        op_seen_r <= op_seen_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  // final character stage
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire && is_last) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_last) begin
      s1_span_r  <= span_nxt;
      s1_start_r <= in_ch.start_pos;
      s1_head_r  <= head_nxt;
      s1_tail_r  <= tail_nxt;
      s1_fwd_r   <= !in_ch.sam_flags[REV_FLAG_BIT];
      s1_err_r   <= err_fin;
    end
  end

  // end position: start + span - 1, clamped
  assign pos_sum = (SPAN_BITS+1)'(s1_start_r) + {1'b0, s1_span_r};
  assign pos_dec = pos_sum - (SPAN_BITS+1)'(1);

  always_comb begin
    if (pos_sum == '0) begin
      end_nxt = '0;
    end else if (|pos_dec[SPAN_BITS:POS_BITS]) begin
      end_nxt = POS_MAX;
    end else begin
      end_nxt = pos_dec[POS_BITS-1:0];
    end
    o_head_nxt = s1_head_r;
    o_tail_nxt = s1_tail_r;
    if (s1_err_r != ERR_NONE) begin
      end_nxt    = '0;
      o_head_nxt = '0;
      o_tail_nxt = '0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      end_r    <= end_nxt;
      o_head_r <= o_head_nxt;
      o_tail_r <= o_tail_nxt;
      o_fwd_r  <= s1_fwd_r;
      o_err_r  <= s1_err_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.end_pos    = end_r;
  assign out_ch.head_clip  = o_head_r;
  assign out_ch.tail_clip  = o_tail_r;
  assign out_ch.is_forward = o_fwd_r;
  assign out_ch.error_code = o_err_r;

endmodule
